FILE: src/smp_pkg.sv
`default_nettype none

package smp_pkg;

  // Default sizes, handed to the top level parameters
  localparam int DefMaxPattern = 32;
  localparam longint unsigned DefMaxText = 64'd65536;

  // Pattern bytes held by the four pattern words
  localparam int PatBytes = 32;
  localparam int NumWords = 4;
  localparam int CfgDataW = 64;
  localparam int CfgAddrW = 6;
  localparam int LenRegW  = 6;

  // Result index fields
  localparam int IdxW = 17;
  localparam logic signed [IdxW-1:0] IdxNone = -17'sd1;
  localparam logic signed [IdxW-1:0] IdxZero = 17'sd0;
  localparam logic signed [IdxW-1:0] IdxSat  = 17'sd65535;

  // Register index (byte address / 8)
  typedef enum logic [2:0] {
    RegPatLen = 3'd0,
    RegWord0  = 3'd1,
    RegWord1  = 3'd2,
    RegWord2  = 3'd3,
    RegWord3  = 3'd4
  } smp_reg_e;

  // Item class as decided by the front end
  typedef enum logic [1:0] {
    ItemByte  = 2'd0,
    ItemLast  = 2'd1,
    ItemEmpty = 2'd2
  } smp_kind_e;

  typedef struct packed {
    smp_kind_e  kind;
    logic [7:0] data;
  } smp_item_t;

  typedef struct packed {
    logic signed [IdxW-1:0] first_index;
    logic signed [IdxW-1:0] last_index;
    logic                   found;
    logic                   prefix_match;
    logic                   suffix_match;
    logic                   too_long;
  } smp_result_t;

endpackage

`default_nettype wire

FILE: src/smp_cfg.sv
`default_nettype none

module smp_cfg #(
  parameter int MAX_PATTERN = smp_pkg::DefMaxPattern,
  localparam int LW = $clog2(MAX_PATTERN + 1),
  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [smp_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [smp_pkg::CfgDataW-1:0]  pwdata,
  output logic      [smp_pkg::CfgDataW-1:0]  prdata,
  output logic                               pready,
  output logic      [7:0]                    aligned_o [MAX_PATTERN],
  output logic      [MAX_PATTERN-1:0]        mask_o,
  output logic      [LW-1:0]                 len_o,
  output logic      [7:0]                    pat_o [MAX_PATTERN]
);

  localparam int CW = (LW > smp_pkg::LenRegW) ? LW : smp_pkg::LenRegW;

  logic [smp_pkg::LenRegW-1:0]  len_q;
  logic [smp_pkg::CfgDataW-1:0] word_q [smp_pkg::NumWords];
  logic [LW-1:0]                len_eff;
  logic [LW-1:0]                len_q2;
  logic [MAX_PATTERN-1:0]       mask_q;
  logic [7:0]                   aligned_q [MAX_PATTERN];
  logic [LW-1:0]                src_idx [MAX_PATTERN];
  smp_pkg::smp_reg_e            reg_idx;
  logic                         wr_en;

  assign pready  = 1'b1;
  assign reg_idx = smp_pkg::smp_reg_e'(paddr[5:3]);
  assign wr_en   = psel && penable && pwrite;

  // Write registers on the access cycle
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      for (int w = 0; w < smp_pkg::NumWords; w++) begin
        word_q[w] <= '0;
      end
    end else if (wr_en) begin
      unique case (reg_idx)
        smp_pkg::RegPatLen: len_q     <= pwdata[smp_pkg::LenRegW-1:0];
        smp_pkg::RegWord0:  word_q[0] <= pwdata;
        smp_pkg::RegWord1:  word_q[1] <= pwdata;
        smp_pkg::RegWord2:  word_q[2] <= pwdata;
        smp_pkg::RegWord3:  word_q[3] <= pwdata;
        default: ;
      endcase
    end
  end

  // Read back
  always_comb begin
    unique case (reg_idx)
      smp_pkg::RegPatLen: prdata = smp_pkg::CfgDataW'(len_q);
      smp_pkg::RegWord0:  prdata = word_q[0];
      smp_pkg::RegWord1:  prdata = word_q[1];
      smp_pkg::RegWord2:  prdata = word_q[2];
      smp_pkg::RegWord3:  prdata = word_q[3];
      default:            prdata = '0;
    endcase
  end

  // Unpack pattern bytes; bytes past the stored words read as zero
  for (genvar j = 0; j < MAX_PATTERN; j++) begin : g_pat
    if (j < smp_pkg::PatBytes) begin : g_real
      assign pat_o[j] = word_q[j / 8][8 * (j % 8) +: 8];
    end else begin : g_zero
      assign pat_o[j] = 8'h00;
    end
  end

  // Saturate the length to the window depth
  assign len_eff = (CW'(len_q) > CW'(MAX_PATTERN)) ? LW'(MAX_PATTERN) : LW'(len_q);

  // Reverse the pattern so window slot k (newest at 0) meets byte len-1-k
  always_comb begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      src_idx[k] = len_eff - LW'(k) - LW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (LW'(k) < len_eff) begin
        aligned_q[k] <= pat_o[IW'(src_idx[k])];
      end else begin
        aligned_q[k] <= 8'h00;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= '0;
      len_q2 <= '0;
    end else begin
      len_q2 <= len_eff;
      for (int k = 0; k < MAX_PATTERN; k++) begin
        mask_q[k] <= (LW'(k) < len_eff);
      end
    end
  end

  assign aligned_o = aligned_q;
  assign mask_o    = mask_q;
  assign len_o     = len_q2;

endmodule

`default_nettype wire

FILE: src/smp_front.sv
`default_nettype none

module smp_front (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic [7:0]  text_byte_i,
  input  wire logic        last_byte_i,
  input  wire logic        empty_text_i,
  output logic             item_valid_o,
  output smp_pkg::smp_item_t item_o,
  input  wire logic        item_take_i
);

  smp_pkg::smp_item_t mem_q [2];
  smp_pkg::smp_item_t item_in;
  logic               wr_ptr_q;
  logic               rd_ptr_q;
  logic [1:0]         count_q;
  logic               do_push;
  logic               do_pop;

  // Classify: a zero-length text wins over the final-byte mark
  always_comb begin
    item_in.data = text_byte_i;
    priority if (empty_text_i) begin
      item_in.kind = smp_pkg::ItemEmpty;
    end else if (last_byte_i) begin
      item_in.kind = smp_pkg::ItemLast;
    end else begin
      item_in.kind = smp_pkg::ItemByte;
    end
  end

  assign full         = (count_q == 2'd2);
  assign item_valid_o = (count_q != 2'd0);
  assign item_o       = mem_q[rd_ptr_q];
  assign do_push      = push && !full;
  assign do_pop       = item_take_i && item_valid_o;

  // Store classified items
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= item_in;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (do_pop) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 2'd1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

FILE: src/smp_back.sv
`default_nettype none

module smp_back #(
  parameter int              MAX_PATTERN = smp_pkg::DefMaxPattern,
  parameter longint unsigned MAX_TEXT    = smp_pkg::DefMaxText,
  localparam int LW = $clog2(MAX_PATTERN + 1),
  localparam int IW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     item_valid_i,
  input  wire smp_pkg::smp_item_t       item_i,
  output logic                          item_take_o,
  input  wire logic [7:0]               aligned_i [MAX_PATTERN],
  input  wire logic [MAX_PATTERN-1:0]   mask_i,
  input  wire logic [LW-1:0]            len_i,
  input  wire logic [7:0]               pat_i [MAX_PATTERN],
  input  wire logic                     pop,
  output logic                          empty,
  output logic signed [smp_pkg::IdxW-1:0] first_index_o,
  output logic signed [smp_pkg::IdxW-1:0] last_index_o,
  output logic                          found_o,
  output logic                          prefix_match_o,
  output logic                          suffix_match_o,
  output logic                          too_long_o
);

  localparam int PW = $clog2(MAX_TEXT + 1);
  localparam int CW = (PW > LW) ? PW : LW;
  localparam int XW = (PW > smp_pkg::IdxW) ? PW : smp_pkg::IdxW;

  // Per-text state
  logic [7:0]    win_q [MAX_PATTERN];
  logic [PW-1:0] pos_q;
  logic [PW-1:0] first_q;
  logic [PW-1:0] last_q;
  logic          first_v_q;
  logic          prefix_q;
  logic          ovf_q;

  logic [7:0]    win_n [MAX_PATTERN];
  logic [PW-1:0] pos_use;
  logic [PW-1:0] start;
  logic [PW-1:0] first_n;
  logic [PW-1:0] last_n;
  logic          first_v_n;
  logic          prefix_n;
  logic          ovf_n;
  logic          shift;
  logic          eq;
  logic          enough;
  logic          len_zero;
  logic          hit;
  logic          pbad;
  logic [IW-1:0] pidx;
  logic          produces;
  logic          step;
  smp_pkg::smp_result_t res;

  // Output queue
  smp_pkg::smp_result_t oq_mem_q [2];
  logic                 oq_wr_q;
  logic                 oq_rd_q;
  logic [1:0]           oq_cnt_q;
  logic                 oq_room;
  logic                 oq_pop;

  function automatic logic signed [smp_pkg::IdxW-1:0] to_idx(input logic v,
                                                             input logic [PW-1:0] p);
    logic [XW-1:0] ext;
    ext = XW'(p);
    if (!v) begin
      return smp_pkg::IdxNone;
    end else if (ext > XW'(smp_pkg::IdxSat)) begin
      return smp_pkg::IdxSat;
    end else begin
      return ext[smp_pkg::IdxW-1:0];
    end
  endfunction

  // Shifted window with the new byte at slot 0
  always_comb begin
    win_n[0] = item_i.data;
    for (int k = 1; k < MAX_PATTERN; k++) begin
      win_n[k] = win_q[k - 1];
    end
  end

  // Compare window against the aligned pattern; drop bytes past the text limit
  always_comb begin
    shift   = (pos_q < PW'(MAX_TEXT));
    pos_use = shift ? (pos_q + PW'(1)) : pos_q;
    eq      = 1'b1;
    for (int k = 0; k < MAX_PATTERN; k++) begin
      if (mask_i[k] && ((shift ? win_n[k] : win_q[k]) != aligned_i[k])) begin
        eq = 1'b0;
      end
    end
    len_zero  = (len_i == '0);
    enough    = (CW'(pos_use) >= CW'(len_i));
    hit       = shift && !len_zero && enough && eq;
    start     = PW'(CW'(pos_use) - CW'(len_i));
    pidx      = IW'(pos_q);
    pbad      = shift && (CW'(pos_q) < CW'(len_i)) && (item_i.data != pat_i[pidx]);
    prefix_n  = prefix_q && !pbad;
    first_v_n = first_v_q || hit;
    first_n   = first_v_q ? first_q : start;
    last_n    = hit ? start : last_q;
    ovf_n     = ovf_q || !shift;
  end

  // Build the result for a finished text
  always_comb begin
    res = '0;
    unique case (item_i.kind)
      smp_pkg::ItemEmpty: begin
        res.first_index  = len_zero ? smp_pkg::IdxZero : smp_pkg::IdxNone;
        res.last_index   = len_zero ? smp_pkg::IdxZero : smp_pkg::IdxNone;
        res.found        = len_zero;
        res.prefix_match = len_zero;
        res.suffix_match = 1'b1;
        res.too_long     = 1'b0;
      end
      smp_pkg::ItemLast: begin
        if (len_zero) begin
          res.first_index  = smp_pkg::IdxNone;
          res.last_index   = smp_pkg::IdxNone;
          res.found        = 1'b0;
          res.prefix_match = 1'b1;
          res.suffix_match = 1'b1;
        end else begin
          res.first_index  = to_idx(first_v_n, first_n);
          res.last_index   = to_idx(first_v_n, last_n);
          res.found        = first_v_n;
          res.prefix_match = enough && prefix_n;
          res.suffix_match = enough && eq;
        end
        res.too_long = ovf_n;
      end
      default: ;
    endcase
  end

  assign produces    = (item_i.kind == smp_pkg::ItemLast) || (item_i.kind == smp_pkg::ItemEmpty);
  assign oq_pop      = pop && !empty;
  assign oq_room     = (oq_cnt_q != 2'd2) || oq_pop;
  assign item_take_o = item_valid_i && (!produces || oq_room);
  assign step        = item_take_o;

  // Update per-text state; clear it once a text ends
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_PATTERN; k++) begin
        win_q[k] <= 8'h00;
      end
      pos_q     <= '0;
      first_q   <= '0;
      last_q    <= '0;
      first_v_q <= 1'b0;
      prefix_q  <= 1'b1;
      ovf_q     <= 1'b0;
    end else if (step) begin
      unique case (item_i.kind)
        smp_pkg::ItemByte: begin
          if (shift) begin
            win_q <= win_n;
          end
          pos_q     <= pos_use;
          first_q   <= first_n;
          last_q    <= last_n;
          first_v_q <= first_v_n;
          prefix_q  <= prefix_n;
          ovf_q     <= ovf_n;
        end
        smp_pkg::ItemLast, smp_pkg::ItemEmpty: begin
          for (int k = 0; k < MAX_PATTERN; k++) begin
            win_q[k] <= 8'h00;
          end
          pos_q     <= '0;
          first_v_q <= 1'b0;
          prefix_q  <= 1'b1;
          ovf_q     <= 1'b0;
        end
        default: ;
      endcase
    end
  end

  // Hold results until taken
  always_ff @(posedge clk_i) begin
    if (step && produces) begin
      oq_mem_q[oq_wr_q] <= res;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      oq_wr_q  <= 1'b0;
      oq_rd_q  <= 1'b0;
      oq_cnt_q <= 2'd0;
    end else begin
      if (step && produces) begin
        oq_wr_q <= !oq_wr_q;
      end
      if (oq_pop) begin
        oq_rd_q <= !oq_rd_q;
      end
      if ((step && produces) && !oq_pop) begin
        oq_cnt_q <= oq_cnt_q + 2'd1;
      end else if (oq_pop && !(step && produces)) begin
        oq_cnt_q <= oq_cnt_q - 2'd1;
      end
    end
  end

  assign empty          = (oq_cnt_q == 2'd0);
  assign first_index_o  = oq_mem_q[oq_rd_q].first_index;
  assign last_index_o   = oq_mem_q[oq_rd_q].last_index;
  assign found_o        = oq_mem_q[oq_rd_q].found;
  assign prefix_match_o = oq_mem_q[oq_rd_q].prefix_match;
  assign suffix_match_o = oq_mem_q[oq_rd_q].suffix_match;
  assign too_long_o     = oq_mem_q[oq_rd_q].too_long;

endmodule

`default_nettype wire

FILE: src/substring_position_matcher.sv
// Channel   Direction  Handshake            Payload
// text      in         push / full          text_byte_i, last_byte_i, empty_text_i
// result    out        empty / pop          first_index_o, last_index_o, found_o,
//                                           prefix_match_o, suffix_match_o, too_long_o
// config    in         psel/penable/pwrite  paddr (8 bytes per register), pwdata, prdata
//
// One text byte per cycle while finishing texts find room in the result queue; a byte
// accepted into the front queue is compared with all pattern bytes and retired by the back end.
// A result is registered in the result queue as the back end retires its final byte.
// Reset clears all control state at once; no clearing pass.
// full rises only when the front queue holds two items, which happens when a
// finishing text finds the two-entry result queue full and pop stays low.
`default_nettype none

module substring_position_matcher #(
  parameter int              MAX_PATTERN = smp_pkg::DefMaxPattern,
  parameter longint unsigned MAX_TEXT    = smp_pkg::DefMaxText
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          push,
  output logic                               full,
  input  wire logic [7:0]                    text_byte_i,
  input  wire logic                          last_byte_i,
  input  wire logic                          empty_text_i,
  input  wire logic                          pop,
  output logic                               empty,
  output logic signed [smp_pkg::IdxW-1:0]    first_index_o,
  output logic signed [smp_pkg::IdxW-1:0]    last_index_o,
  output logic                               found_o,
  output logic                               prefix_match_o,
  output logic                               suffix_match_o,
  output logic                               too_long_o,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [smp_pkg::CfgAddrW-1:0]  paddr,
  input  wire logic [smp_pkg::CfgDataW-1:0]  pwdata,
  output logic      [smp_pkg::CfgDataW-1:0]  prdata,
  output logic                               pready
);

  localparam int LW = $clog2(MAX_PATTERN + 1);

  logic [7:0]             aligned [MAX_PATTERN];
  logic [7:0]             pat [MAX_PATTERN];
  logic [MAX_PATTERN-1:0] mask;
  logic [LW-1:0]          len;
  logic                   item_valid;
  logic                   item_take;
  smp_pkg::smp_item_t     item;

  smp_cfg #(
    .MAX_PATTERN(MAX_PATTERN)
  ) u_cfg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready),
    .aligned_o(aligned),
    .mask_o   (mask),
    .len_o    (len),
    .pat_o    (pat)
  );

  smp_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push        (push),
    .full        (full),
    .text_byte_i (text_byte_i),
    .last_byte_i (last_byte_i),
    .empty_text_i(empty_text_i),
    .item_valid_o(item_valid),
    .item_o      (item),
    .item_take_i (item_take)
  );

  smp_back #(
    .MAX_PATTERN(MAX_PATTERN),
    .MAX_TEXT   (MAX_TEXT)
  ) u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_valid_i  (item_valid),
    .item_i        (item),
    .item_take_o   (item_take),
    .aligned_i     (aligned),
    .mask_i        (mask),
    .len_i         (len),
    .pat_i         (pat),
    .pop           (pop),
    .empty         (empty),
    .first_index_o (first_index_o),
    .last_index_o  (last_index_o),
    .found_o       (found_o),
    .prefix_match_o(prefix_match_o),
    .suffix_match_o(suffix_match_o),
    .too_long_o    (too_long_o)
  );

endmodule

`default_nettype wire

FILE: src/smp_checker.sv
`default_nettype none

module smp_checker (
  input wire logic                              clk_i,
  input wire logic                              rst_ni,
  input wire logic                              empty,
  input wire logic                              pop,
  input wire logic signed [smp_pkg::IdxW-1:0]   first_index_o,
  input wire logic signed [smp_pkg::IdxW-1:0]   last_index_o,
  input wire logic                              found_o,
  input wire logic                              prefix_match_o,
  input wire logic                              suffix_match_o,
  input wire logic                              too_long_o
);

  // Hold a waiting result until it is taken
  a_result_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> (!empty && $stable(first_index_o) && $stable(last_index_o)
      && $stable(found_o) && $stable(prefix_match_o) && $stable(suffix_match_o)
      && $stable(too_long_o)))
    else $error("result changed before its transaction completed");

  // found agrees with both indices
  a_found_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (found_o == (first_index_o != smp_pkg::IdxNone))
      && (found_o == (last_index_o != smp_pkg::IdxNone)))
    else $error("found disagrees with reported indices");

  // Last match never starts before the first
  a_idx_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && found_o) |-> (last_index_o >= first_index_o))
    else $error("last match starts before first match");

endmodule

bind substring_position_matcher smp_checker u_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .empty         (empty),
  .pop           (pop),
  .first_index_o (first_index_o),
  .last_index_o  (last_index_o),
  .found_o       (found_o),
  .prefix_match_o(prefix_match_o),
  .suffix_match_o(suffix_match_o),
  .too_long_o    (too_long_o)
);

`default_nettype wire
